>>> design/scm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the stereo channel mixer with peak meters.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Width of the channel count register
  localparam int unsigned CNT_W = 6;

  // Width of a peak meter reading (0..65535)
  localparam int unsigned PEAK_W = 16;

  // Item kinds
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  // Per-side control from the frame sequencer to a mixer lane
  typedef struct packed {
    logic sample_step;  // a channel sample is taken this cycle
    logic frame_end;    // this sample closes the frame
    logic meter_clear;  // zero the peak meter
  } side_ctrl_t;

endpackage

>>> design/scm_side.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_side
// One mixer lane: accumulates one side's samples over a frame, scales the
// frame sum into a 0..65535 meter reading, tracks its peak and flags clipping.
// ----------------------------------------------------------------------------
module scm_side #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  scm_pkg::side_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic signed [SAMPLE_BITS+4:0]       sum_o,
  output logic        [scm_pkg::PEAK_W-1:0]   peak_o,
  output logic                                clip_o
);

  localparam int unsigned ACC_W = SAMPLE_BITS + 5;
  localparam int unsigned PRD_W = SAMPLE_BITS + scm_pkg::PEAK_W;
  localparam logic [ACC_W-1:0] FullScale = ACC_W'(1) << (SAMPLE_BITS - 1);

  logic signed [ACC_W-1:0]           acc_q, acc_d;
  logic        [scm_pkg::PEAK_W-1:0] peak_q, peak_d;
  logic signed [ACC_W-1:0]           sum;
  logic        [ACC_W-1:0]           mag;
  logic                              over;
  logic        [SAMPLE_BITS-1:0]     mag_clamped;
  logic        [PRD_W-1:0]           scaled;
  logic        [scm_pkg::PEAK_W-1:0] meter;
  logic        [scm_pkg::PEAK_W-1:0] peak_new;

  // Add the sample into the running frame sum
  assign sum = acc_q + ACC_W'(sample_i);

  // Magnitude, clamped to full scale
  assign mag         = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
  assign over        = mag > FullScale;
  assign mag_clamped = over ? FullScale[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];

  // Scale by 65535 as (mag << 16) - mag, then drop the fraction bits
  assign scaled = {mag_clamped, {scm_pkg::PEAK_W{1'b0}}} - PRD_W'(mag_clamped);
  assign meter  = scaled[SAMPLE_BITS-1 +: scm_pkg::PEAK_W];

  // Keep the largest reading
  assign peak_new = (meter > peak_q) ? meter : peak_q;

  // Advance the accumulator and the meter
  always_comb begin
    acc_d  = acc_q;
    peak_d = peak_q;
    if (ctrl_i.meter_clear) begin
      peak_d = '0;
    end else if (ctrl_i.sample_step) begin
      if (ctrl_i.frame_end) begin
        acc_d  = '0;
        peak_d = peak_new;
      end else begin
        acc_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      peak_q <= '0;
    end else begin
      acc_q  <= acc_d;
      peak_q <= peak_d;
    end
  end

  assign sum_o  = sum;
  assign peak_o = peak_new;
  assign clip_o = over;

endmodule

>>> design/stereo_channel_mixer_peak_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_channel_mixer_peak_meter
// Sums channel_count stereo channel samples into one frame, meters the
// frame peaks and flags clipping per frame and per block.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  kind, left_in, right_in, block_start
//   out      source     out_valid/stall    mix_l/r, peak_l/r, frame/block clip
//   cfg      sink       cfg_valid/ready    channel_count
//
// One item per cycle while no result stalls; the result of a frame loads into
// the output register as its last beat leaves the input register.
// Every lane computation is one add, a negate, a shift-subtract and compares.
// Reset clears accumulators, meters, sticky flag and sets channel_count to 1.
// A stalled result holds the input register, which then stalls the input.
// ----------------------------------------------------------------------------
module stereo_channel_mixer_peak_meter #(
  parameter int unsigned MAX_CHANNELS = 32,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic signed [SAMPLE_BITS-1:0]     left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]     right_in_i,
  input  logic                              block_start_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS+4:0]     mix_left_o,
  output logic signed [SAMPLE_BITS+4:0]     mix_right_o,
  output logic        [scm_pkg::PEAK_W-1:0] peak_left_o,
  output logic        [scm_pkg::PEAK_W-1:0] peak_right_o,
  output logic                              frame_clipped_o,
  output logic                              block_clipped_o,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [scm_pkg::CNT_W-1:0]  cfg_data_i
);

  localparam int unsigned ACC_W = SAMPLE_BITS + 5;
  localparam int unsigned CMP_W = 9;
  localparam logic [CMP_W-1:0] MaxCount = CMP_W'(MAX_CHANNELS);

  // Input register
  logic                          in_vld_q, in_vld_d;
  scm_pkg::kind_e                kind_q;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic                          bstart_q;

  // Sequencer state
  logic [scm_pkg::CNT_W-1:0] count_q;
  logic [scm_pkg::CNT_W-1:0] index_q, index_d, index_inc;
  logic                      sticky_q, sticky_d, sticky_base;
  logic [CMP_W-1:0]          count_wide, count_eff;

  // Output register
  logic                          out_vld_q, out_vld_d;
  logic signed [ACC_W-1:0]       mix_l_q, mix_r_q;
  logic [scm_pkg::PEAK_W-1:0]    peak_l_q, peak_r_q;
  logic                          fclip_q, bclip_q;

  logic                          advance, accept;
  logic                          is_sample, frame_end, frame_clip;
  scm_pkg::side_ctrl_t           ctrl;
  logic signed [ACC_W-1:0]       sum_l, sum_r;
  logic [scm_pkg::PEAK_W-1:0]    peak_l, peak_r;
  logic                          clip_l, clip_r;

  // Handshakes
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Clamp the channel count to 1..MAX_CHANNELS
  assign count_wide = CMP_W'(count_q);
  always_comb begin
    priority if (count_wide == '0) begin
      count_eff = CMP_W'(1);
    end else if (count_wide > MaxCount) begin
      count_eff = MaxCount;
    end else begin
      count_eff = count_wide;
    end
  end

  // Frame sequencing
  assign is_sample = (kind_q == scm_pkg::KIND_SAMPLE);
  assign index_inc = index_q + scm_pkg::CNT_W'(1);
  assign frame_end = CMP_W'(index_inc) >= count_eff;

  assign ctrl.sample_step = advance && is_sample;
  assign ctrl.frame_end   = frame_end;
  assign ctrl.meter_clear = advance && !is_sample;

  scm_side #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_side_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .sample_i(left_q),
    .sum_o   (sum_l),
    .peak_o  (peak_l),
    .clip_o  (clip_l)
  );

  scm_side #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_side_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .sample_i(right_q),
    .sum_o   (sum_r),
    .peak_o  (peak_r),
    .clip_o  (clip_r)
  );

  assign frame_clip  = clip_l || clip_r;
  assign sticky_base = bstart_q ? 1'b0 : sticky_q;

  // Advance the channel index and the sticky clip flag
  always_comb begin
    index_d  = index_q;
    sticky_d = sticky_q;
    if (advance) begin
      sticky_d = sticky_base;
      if (is_sample) begin
        if (frame_end) begin
          index_d  = '0;
          sticky_d = sticky_base || frame_clip;
        end else begin
          index_d = index_inc;
        end
      end
    end
  end

  // Input register: load on accept, drop once processed
  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Output register: load on frame end, drop once taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (ctrl.sample_step && frame_end) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= scm_pkg::CNT_W'(1);
      index_q   <= '0;
      sticky_q  <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      index_q   <= index_d;
      sticky_q  <= sticky_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= scm_pkg::kind_e'(kind_i);
      left_q   <= left_in_i;
      right_q  <= right_in_i;
      bstart_q <= block_start_i;
    end
    if (ctrl.sample_step && frame_end) begin
      mix_l_q  <= sum_l;
      mix_r_q  <= sum_r;
      peak_l_q <= peak_l;
      peak_r_q <= peak_r;
      fclip_q  <= frame_clip;
      bclip_q  <= sticky_base || frame_clip;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign mix_left_o      = mix_l_q;
  assign mix_right_o     = mix_r_q;
  assign peak_left_o     = peak_l_q;
  assign peak_right_o    = peak_r_q;
  assign frame_clipped_o = fclip_q;
  assign block_clipped_o = bclip_q;

endmodule

>>> verif/tb_stereo_channel_mixer_peak_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_channel_mixer_peak_meter
// Self-checking bench for the stereo mixer with peak meters. A short table of
// directed beats, then random phases under varying channel counts and idle
// patterns on both channels. A local predictor tracks the accumulators, the
// meters and the sticky clip flag; every output frame is compared field by
// field with the oldest queued frame, the table's own for typed rows.
// ----------------------------------------------------------------------------
module tb_stereo_channel_mixer_peak_meter;

  localparam int unsigned SB         = 16;
  localparam int unsigned MAX_CH     = 32;
  localparam int unsigned MIX_W      = SB + 5;
  localparam int unsigned PEAK_W     = scm_pkg::PEAK_W;
  localparam int unsigned CNT_W      = scm_pkg::CNT_W;
  localparam longint      FULL_SCALE = 64'sd1 << (SB - 1);
  localparam int          QUIET_MAX  = 2000;
  localparam int          PHASES     = 12;
  localparam int          PHASE_BEATS = 125;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_op_e;

  typedef struct packed {
    scm_pkg::kind_e       kind;
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 block_start;
  } beat_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_l;
    logic signed [MIX_W-1:0] mix_r;
    logic [PEAK_W-1:0]       peak_l;
    logic [PEAK_W-1:0]       peak_r;
    logic                    fclip;
    logic                    bclip;
  } frame_t;

  typedef struct packed {
    row_op_e          op;
    beat_t            b;
    int               reps;
    logic [CNT_W-1:0] cfg;
    logic             typed;
    frame_t           want;
  } dir_row_t;

  // DUT signals
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    kind_i = 1'b0;
  logic signed [SB-1:0]    left_in_i = '0;
  logic signed [SB-1:0]    right_in_i = '0;
  logic                    block_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [MIX_W-1:0] mix_left_o;
  logic signed [MIX_W-1:0] mix_right_o;
  logic [PEAK_W-1:0]       peak_left_o;
  logic [PEAK_W-1:0]       peak_right_o;
  logic                    frame_clipped_o;
  logic                    block_clipped_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CNT_W-1:0]        cfg_data_i = '0;

  // Predictor state
  logic signed [MIX_W-1:0] mix_acc_l = '0;
  logic signed [MIX_W-1:0] mix_acc_r = '0;
  int unsigned             frame_fill = 0;
  logic [PEAK_W-1:0]       meter_l = '0;
  logic [PEAK_W-1:0]       meter_r = '0;
  logic                    clip_hold = 1'b0;
  logic [CNT_W-1:0]        chan_cfg = CNT_W'(1);

  frame_t   pending_frames[$];
  dir_row_t dir_tab[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  stereo_channel_mixer_peak_meter #(
    .MAX_CHANNELS(MAX_CH),
    .SAMPLE_BITS (SB)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .block_start_i  (block_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mix_left_o     (mix_left_o),
    .mix_right_o    (mix_right_o),
    .peak_left_o    (peak_left_o),
    .peak_right_o   (peak_right_o),
    .frame_clipped_o(frame_clipped_o),
    .block_clipped_o(block_clipped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Meter reading: clamp the magnitude to full scale, then scale to 0..65535
  function automatic logic [PEAK_W-1:0] meter_reading(input logic signed [MIX_W-1:0] sum);
    longint mag;
    mag = (sum < 0) ? -longint'(sum) : longint'(sum);
    if (mag > FULL_SCALE) mag = FULL_SCALE;
    return PEAK_W'((mag * 65535) >>> (SB - 1));
  endfunction

  function automatic logic beyond_full(input logic signed [MIX_W-1:0] sum);
    return (longint'(sum) > FULL_SCALE) || (longint'(sum) < -FULL_SCALE);
  endfunction

  // Advance the mixer state by one beat; return 1 when a frame closes
  function automatic bit mix_step(input beat_t b, output frame_t f);
    int unsigned span;
    logic [PEAK_W-1:0] pl, pr;
    f = '0;
    if (b.block_start) clip_hold = 1'b0;
    if (b.kind == scm_pkg::KIND_CLEAR) begin
      meter_l = '0;
      meter_r = '0;
      return 1'b0;
    end
    span = chan_cfg;
    if (span < 1) span = 1;
    if (span > MAX_CH) span = MAX_CH;
    mix_acc_l = mix_acc_l + b.left;
    mix_acc_r = mix_acc_r + b.right;
    frame_fill++;
    if (frame_fill < span) return 1'b0;
    pl = meter_reading(mix_acc_l);
    pr = meter_reading(mix_acc_r);
    if (pl > meter_l) meter_l = pl;
    if (pr > meter_r) meter_r = pr;
    f.fclip = beyond_full(mix_acc_l) || beyond_full(mix_acc_r);
    clip_hold = clip_hold | f.fclip;
    f.mix_l  = mix_acc_l;
    f.mix_r  = mix_acc_r;
    f.peak_l = meter_l;
    f.peak_r = meter_r;
    f.bclip  = clip_hold;
    mix_acc_l = '0;
    mix_acc_r = '0;
    frame_fill = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Drive one beat from a falling edge until accepted, then predict it
  task automatic send_beat(input beat_t b, input logic typed, input frame_t want);
    bit taken;
    frame_t f;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= b.kind;
    left_in_i     <= b.left;
    right_in_i    <= b.right;
    block_start_i <= b.block_start;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (!taken) @(negedge clk_i);
    end
    if (mix_step(b, f)) pending_frames.push_back(typed ? want : f);
    @(negedge clk_i);
  endtask

  // Write the channel count once the pipeline has drained
  task automatic write_count(input logic [CNT_W-1:0] value);
    bit taken;
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    // let trailing clear or partial-frame beats leave the pipeline
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = cfg_ready_o;
      if (!taken) @(negedge clk_i);
    end
    chan_cfg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_beat(input scm_pkg::kind_e k, input int l, input int r,
                                   input bit bs, input int reps, input bit typed,
                                   input int ml = 0, input int mr = 0, input int pl = 0,
                                   input int pr = 0, input bit fc = 0, input bit bc = 0);
    dir_row_t row;
    row = '0;
    row.op            = ROW_BEAT;
    row.b.kind        = k;
    row.b.left        = SB'(l);
    row.b.right       = SB'(r);
    row.b.block_start = bs;
    row.reps          = reps;
    row.typed         = typed;
    row.want.mix_l    = MIX_W'(ml);
    row.want.mix_r    = MIX_W'(mr);
    row.want.peak_l   = PEAK_W'(pl);
    row.want.peak_r   = PEAK_W'(pr);
    row.want.fclip    = fc;
    row.want.bclip    = bc;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_cfg(input int value);
    dir_row_t row;
    row = '0;
    row.op  = ROW_CFG;
    row.cfg = CNT_W'(value);
    dir_tab.push_back(row);
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? SB'(32767) : SB'(-32768);
      1: return SB'($urandom);
      2: return SB'(int'($urandom_range(0, 511)) - 256);
      default: return SB'(($urandom_range(0, 1) << (SB - 1)) | $urandom_range(0, 32767));
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    b.kind        = ($urandom_range(0, 24) == 0) ? scm_pkg::KIND_CLEAR : scm_pkg::KIND_SAMPLE;
    b.left        = rand_sample();
    b.right       = rand_sample();
    b.block_start = ($urandom_range(0, 15) == 0);
    return b;
  endfunction

  // Receiver stall pattern
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check accepted frames and guard against a hang
  always @(posedge clk_i) begin
    frame_t exp_f;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("stereo_channel_mixer_peak_meter: mismatch");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_frames.size() == 0) begin
          report_mismatch("frame beat with no frame predicted");
        end else begin
          exp_f = pending_frames.pop_front();
          if (mix_left_o !== exp_f.mix_l)
            report_mismatch($sformatf("mix_left %0d, want %0d", mix_left_o, exp_f.mix_l));
          if (mix_right_o !== exp_f.mix_r)
            report_mismatch($sformatf("mix_right %0d, want %0d", mix_right_o, exp_f.mix_r));
          if (peak_left_o !== exp_f.peak_l)
            report_mismatch($sformatf("peak_left %0d, want %0d", peak_left_o, exp_f.peak_l));
          if (peak_right_o !== exp_f.peak_r)
            report_mismatch($sformatf("peak_right %0d, want %0d", peak_right_o, exp_f.peak_r));
          if (frame_clipped_o !== exp_f.fclip)
            report_mismatch($sformatf("frame_clipped %b, want %b", frame_clipped_o,
                                      exp_f.fclip));
          if (block_clipped_o !== exp_f.bclip)
            report_mismatch($sformatf("block_clipped %b, want %b", block_clipped_o,
                                      exp_f.bclip));
        end
      end
    end
  end

  initial begin
    int cnt;
    // Directed table; the count is 1 after reset
    add_beat(scm_pkg::KIND_SAMPLE, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_beat(scm_pkg::KIND_SAMPLE, 32767, -32768, 0, 1, 1,
             32767, -32768, 65533, 65535, 0, 0);
    add_beat(scm_pkg::KIND_SAMPLE, -32768, 32767, 0, 1, 1,
             -32768, 32767, 65535, 65535, 0, 0);
    // clear item that also starts a block
    add_beat(scm_pkg::KIND_CLEAR, 1234, -1234, 1, 1, 0);
    add_beat(scm_pkg::KIND_SAMPLE, 1, -1, 0, 1, 1, 1, -1, 1, 1, 0, 0);
    add_cfg(2);
    add_beat(scm_pkg::KIND_SAMPLE, 32767, 32767, 0, 2, 1,
             65534, 65534, 65535, 65535, 1, 1);
    // sum of exactly full scale does not clip
    add_beat(scm_pkg::KIND_SAMPLE, 16384, 16384, 1, 2, 1,
             32768, 32768, 65535, 65535, 0, 0);
    // a sum two past negative full scale clips
    add_beat(scm_pkg::KIND_SAMPLE, -16385, -16384, 0, 2, 1,
             -32770, -32768, 65535, 65535, 1, 1);
    add_beat(scm_pkg::KIND_CLEAR, 0, 0, 0, 1, 0);
    add_beat(scm_pkg::KIND_SAMPLE, 100, -100, 0, 2, 0);
    // change the count mid-frame, zero acting as one
    add_beat(scm_pkg::KIND_SAMPLE, 5, 7, 0, 1, 0);
    add_cfg(0);
    add_beat(scm_pkg::KIND_SAMPLE, 5, 7, 0, 1, 0);
    add_beat(scm_pkg::KIND_SAMPLE, -3, 4, 0, 1, 0);
    // widest sums
    add_cfg(32);
    add_beat(scm_pkg::KIND_SAMPLE, 32767, -32768, 0, 32, 1,
             1048544, -1048576, 65535, 65535, 1, 1);
    // count above the maximum acts as the maximum
    add_cfg(63);
    add_beat(scm_pkg::KIND_SAMPLE, -32768, 32767, 0, 32, 1,
             -1048576, 1048544, 65535, 65535, 1, 1);
    add_beat(scm_pkg::KIND_CLEAR, -32768, 32767, 1, 1, 0);
    add_cfg(1);

    // Reset
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        write_count(dir_tab[i].cfg);
      end else begin
        repeat (dir_tab[i].reps) send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases, each with its own count and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       cnt = 0;
        1:       cnt = MAX_CH;
        2:       cnt = $urandom_range(33, 63);
        default: cnt = $urandom_range(1, 8);
      endcase
      write_count(CNT_W'(cnt));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      repeat (PHASE_BEATS) send_beat(rand_beat(), 1'b0, '0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end

    // Drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("stereo_channel_mixer_peak_meter: match");
    end else begin
      $display("stereo_channel_mixer_peak_meter: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/scm_pkg.sv
design/scm_side.sv
design/stereo_channel_mixer_peak_meter.sv
verif/tb_stereo_channel_mixer_peak_meter.sv
